// ----- design/dirty_rect_accumulator_top_macros.svh -----
// Assertion macros shared by the dirty rectangle accumulator.
// No dependencies.
`ifndef DIRTY_RECT_ACCUMULATOR_TOP_MACROS_SVH
`define DIRTY_RECT_ACCUMULATOR_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define DRA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DRA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- design/dra_pkg.sv -----
// Types and constants for the dirty rectangle accumulator.
// No dependencies.
package dra_pkg;
	localparam int MaxRegions = 8;
	localparam int IdxW = $clog2(MaxRegions);
	localparam int CntW = $clog2(MaxRegions + 1);
	localparam logic [12:0] ScreenLimit = 13'd4096;
	localparam logic [12:0] ResetWidth = 13'd320;
	localparam logic [12:0] ResetHeight = 13'd240;
	localparam logic ActAdd = 1'b0;
	localparam logic ActFlush = 1'b1;
	localparam logic RegWidth = 1'b0;
	localparam logic RegHeight = 1'b1;

	// Stored region: corners inside the screen, sizes up to 4096.
	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [12:0] w;
		logic [12:0] h;
	} box_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLIP,
		ST_RD,
		ST_CHK,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_APPEND,
		ST_FULL_RD,
		ST_FULL_MUL,
		ST_FULL_CMP,
		ST_FULL_WR,
		ST_FL_RD,
		ST_FL_OUT,
		ST_FL_EMPTY
	} state_t;
endpackage

// ----- design/dirty_rect_accumulator_top.sv -----
// Top level of the dirty rectangle accumulator: region memory and scan sequencer.
// Depends on dra_pkg and dirty_rect_accumulator_top_macros.svh.
//
//  channel | direction | handshake        | payload
//  in      | sink      | valid / ready    | action rect_x rect_y rect_w rect_h
//  out     | source    | out_valid / out_ready | out_x out_y out_w out_h region_valid last
//  cfg     | APB       | psel penable pready | paddr pwdata prdata
//
// An add clips the rectangle, then reads and checks each stored entry in turn;
// each merge moves the last entry into the merged slot and restarts the scan.
// A full list adds a least-growth search that reads every entry in turn over the
// single memory read port. A flush reads out each entry and waits on output stalls.
// Reset clears the state, entry count, index and output valid; the memory needs no clearing pass.
// Input ready is low while an item is in work; out_ready low holds a flush with out_valid high.
`include "dirty_rect_accumulator_top_macros.svh"
module dirty_rect_accumulator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic        action,
	input  logic signed [15:0] rect_x,
	input  logic signed [15:0] rect_y,
	input  logic [14:0] rect_w,
	input  logic [14:0] rect_h,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] out_x,
	output logic [11:0] out_y,
	output logic [12:0] out_w,
	output logic [12:0] out_h,
	output logic        region_valid,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int IW = dra_pkg::IdxW;
	localparam int CW = dra_pkg::CntW;

	dra_pkg::state_t state_q, state_d;
	logic [12:0] sw_q, sh_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] best_q;
	logic [26:0] best_g_q;
	dra_pkg::box_t r_q, m_q, best_box_q, rd_s1;
	logic [25:0] area_new_q, area_old_q;
	logic signed [17:0] in_x_q, in_y_q;
	logic [14:0] in_w_q, in_h_q;
	logic [11:0] ox_q, oy_q;
	logic [12:0] ow_q, oh_q;
	logic ovld_q, orv_q, olast_q;

	dra_pkg::box_t mem [dra_pkg::MaxRegions];
	logic [IW-1:0] rd_addr, wr_addr;
	logic wr_en;
	dra_pkg::box_t wr_data;

	// Configuration port.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= dra_pkg::ResetWidth;
			sh_q <= dra_pkg::ResetHeight;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			if (paddr[2] == dra_pkg::RegWidth) sw_q <= pwdata[12:0];
			else sh_q <= pwdata[12:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			prdata[12:0] = (paddr[2] == dra_pkg::RegWidth) ? sw_q : sh_q;
		end
	end

	// Region memory, one read and one write port.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_s1 <= mem[rd_addr];
	end

	// Clipping, done on registered inputs.
	logic signed [17:0] sw_e, sh_e, c_l, c_t, c_r, c_b, rx_end, ry_end;
	always_comb begin
		sw_e = (sw_q > dra_pkg::ScreenLimit) ? 18'sd4096 : $signed({5'd0, sw_q});
		sh_e = (sh_q > dra_pkg::ScreenLimit) ? 18'sd4096 : $signed({5'd0, sh_q});
		rx_end = in_x_q + $signed({3'd0, in_w_q});
		ry_end = in_y_q + $signed({3'd0, in_h_q});
		c_l = (in_x_q < 0) ? 18'sd0 : in_x_q;
		c_t = (in_y_q < 0) ? 18'sd0 : in_y_q;
		c_r = (rx_end < sw_e) ? rx_end : sw_e;
		c_b = (ry_end < sh_e) ? ry_end : sh_e;
	end

	// Touch test and union between stored entry and working rectangle.
	logic [13:0] a_r, a_b, b_r, b_b, u_r, u_b;
	logic [11:0] u_x, u_y;
	logic touch;
	dra_pkg::box_t u_box;
	always_comb begin
		a_r = {2'd0, rd_s1.x} + {1'b0, rd_s1.w};
		a_b = {2'd0, rd_s1.y} + {1'b0, rd_s1.h};
		b_r = {2'd0, r_q.x} + {1'b0, r_q.w};
		b_b = {2'd0, r_q.y} + {1'b0, r_q.h};
		touch = ({2'd0, rd_s1.x} <= b_r) && ({2'd0, r_q.x} <= a_r) &&
			({2'd0, rd_s1.y} <= b_b) && ({2'd0, r_q.y} <= a_b);
		u_x = (rd_s1.x < r_q.x) ? rd_s1.x : r_q.x;
		u_y = (rd_s1.y < r_q.y) ? rd_s1.y : r_q.y;
		u_r = (a_r > b_r) ? a_r : b_r;
		u_b = (a_b > b_b) ? a_b : b_b;
		u_box.x = u_x;
		u_box.y = u_y;
		u_box.w = 13'(u_r - {2'd0, u_x});
		u_box.h = 13'(u_b - {2'd0, u_y});
	end

	logic [26:0] growth;
	assign growth = {1'b0, area_new_q} - {1'b0, area_old_q};

	logic in_acc, out_acc, last_idx, ovld_set;
	assign in_acc = valid && ready;
	assign out_acc = out_valid && out_ready;
	assign last_idx = (idx_q + 1'b1 == cnt_q);
	// Load the output register on a flush beat; an empty flush waits for room.
	assign ovld_set = (state_q == dra_pkg::ST_FL_OUT) ||
		((state_q == dra_pkg::ST_FL_EMPTY) && (!ovld_q || out_ready));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dra_pkg::ST_IDLE: if (in_acc) state_d = (action == dra_pkg::ActFlush)
				? ((cnt_q == '0) ? dra_pkg::ST_FL_EMPTY : dra_pkg::ST_FL_RD)
				: dra_pkg::ST_CLIP;
			dra_pkg::ST_CLIP: begin
				if (c_l >= c_r || c_t >= c_b) state_d = dra_pkg::ST_IDLE;
				else if (cnt_q == '0) state_d = dra_pkg::ST_APPEND;
				else state_d = dra_pkg::ST_RD;
			end
			dra_pkg::ST_RD: state_d = dra_pkg::ST_CHK;
			dra_pkg::ST_CHK: begin
				if (touch) state_d = dra_pkg::ST_MOVE_RD;
				else if (last_idx) state_d = (cnt_q == CW'(dra_pkg::MaxRegions))
					? dra_pkg::ST_FULL_RD : dra_pkg::ST_APPEND;
				else state_d = dra_pkg::ST_RD;
			end
			dra_pkg::ST_MOVE_RD: state_d = dra_pkg::ST_MOVE_WR;
			dra_pkg::ST_MOVE_WR: state_d = (cnt_q == '0) ? dra_pkg::ST_APPEND
				: dra_pkg::ST_RD;
			dra_pkg::ST_APPEND: state_d = dra_pkg::ST_IDLE;
			dra_pkg::ST_FULL_RD: state_d = dra_pkg::ST_FULL_MUL;
			dra_pkg::ST_FULL_MUL: state_d = dra_pkg::ST_FULL_CMP;
			dra_pkg::ST_FULL_CMP: state_d = last_idx ? dra_pkg::ST_FULL_WR
				: dra_pkg::ST_FULL_RD;
			dra_pkg::ST_FULL_WR: state_d = dra_pkg::ST_IDLE;
			dra_pkg::ST_FL_RD: if (!ovld_q || out_ready) state_d = dra_pkg::ST_FL_OUT;
			dra_pkg::ST_FL_OUT: state_d = last_idx ? dra_pkg::ST_IDLE
				: dra_pkg::ST_FL_RD;
			dra_pkg::ST_FL_EMPTY: if (!ovld_q || out_ready) state_d = dra_pkg::ST_IDLE;
			default: state_d = dra_pkg::ST_IDLE;
		endcase
	end

	// Memory control outputs.
	always_comb begin
		rd_addr = idx_q[IW-1:0];
		wr_en = 1'b0;
		wr_addr = idx_q[IW-1:0];
		wr_data = rd_s1;
		unique case (state_q)
			dra_pkg::ST_MOVE_RD: rd_addr = IW'(cnt_q - 1'b1);
			dra_pkg::ST_MOVE_WR: wr_en = 1'b1;
			dra_pkg::ST_APPEND: begin
				wr_en = 1'b1;
				wr_addr = cnt_q[IW-1:0];
				wr_data = r_q;
			end
			dra_pkg::ST_FULL_WR: begin
				wr_en = 1'b1;
				wr_addr = best_q;
				wr_data = best_box_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dra_pkg::ST_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			ovld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ovld_set) ovld_q <= 1'b1;
			else if (out_acc) ovld_q <= 1'b0;
			unique case (state_q)
				dra_pkg::ST_IDLE: idx_q <= '0;
				dra_pkg::ST_CHK: begin
					if (!touch && !last_idx) idx_q <= idx_q + 1'b1;
					else if (!touch) idx_q <= '0;
				end
				dra_pkg::ST_MOVE_RD: cnt_q <= cnt_q - 1'b1;
				dra_pkg::ST_MOVE_WR: idx_q <= '0;
				dra_pkg::ST_APPEND: cnt_q <= cnt_q + 1'b1;
				dra_pkg::ST_FULL_CMP: idx_q <= idx_q + 1'b1;
				dra_pkg::ST_FL_RD: ;
				dra_pkg::ST_FL_OUT: begin
					if (last_idx) cnt_q <= '0;
					else idx_q <= idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_x_q <= 18'(rect_x);
			in_y_q <= 18'(rect_y);
			in_w_q <= rect_w;
			in_h_q <= rect_h;
		end
		unique case (state_q)
			dra_pkg::ST_CLIP: begin
				r_q.x <= c_l[11:0];
				r_q.y <= c_t[11:0];
				r_q.w <= 13'(c_r - c_l);
				r_q.h <= 13'(c_b - c_t);
			end
			dra_pkg::ST_CHK: if (touch) r_q <= u_box;
			dra_pkg::ST_FULL_MUL: begin
				m_q <= u_box;
				area_new_q <= u_box.w * u_box.h;
				area_old_q <= rd_s1.w * rd_s1.h;
			end
			dra_pkg::ST_FULL_CMP: if (idx_q == '0 || growth < best_g_q) begin
				best_g_q <= growth;
				best_q <= idx_q[IW-1:0];
				best_box_q <= m_q;
			end
			dra_pkg::ST_FL_OUT: begin
				ox_q <= rd_s1.x;
				oy_q <= rd_s1.y;
				ow_q <= rd_s1.w;
				oh_q <= rd_s1.h;
				orv_q <= 1'b1;
				olast_q <= last_idx;
			end
			dra_pkg::ST_FL_EMPTY: if (!ovld_q || out_ready) begin
				ox_q <= '0;
				oy_q <= '0;
				ow_q <= '0;
				oh_q <= '0;
				orv_q <= 1'b0;
				olast_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign ready = (state_q == dra_pkg::ST_IDLE);
	assign out_valid = ovld_q;
	assign out_x = ox_q;
	assign out_y = oy_q;
	assign out_w = ow_q;
	assign out_h = oh_q;
	assign region_valid = orv_q;
	assign last = olast_q;

	`DRA_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CW'(dra_pkg::MaxRegions))
	`DRA_ASSERT_IMPL(a_append_room, state_q == dra_pkg::ST_APPEND,
		cnt_q < CW'(dra_pkg::MaxRegions))
	`DRA_ASSERT_NEXT(a_flush_clears, state_q == dra_pkg::ST_FL_OUT && last_idx, cnt_q == '0)
	`DRA_ASSERT_IMPL(a_out_hold_stall, out_valid && !out_ready &&
		state_q == dra_pkg::ST_FL_RD, state_d == dra_pkg::ST_FL_RD)
endmodule

// ----- tb/dirty_rect_accumulator_top_tb.sv -----
// Testbench for the dirty rectangle accumulator: drives add and flush transactions,
// predicts the flushed region list and checks every output transaction in order.
// Depends on dra_pkg and the dirty_rect_accumulator_top RTL.
`timescale 1ns / 100ps
module dirty_rect_accumulator_top_tb;
	localparam logic [2:0] AddrWidth = 3'd0;
	localparam logic [2:0] AddrHeight = 3'd4;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [12:0] w;
		logic [12:0] h;
		logic        rv;
		logic        lst;
	} region_out_t;

	typedef struct {
		int x;
		int y;
		int w;
		int h;
	} rect_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid = 1'b0;
	logic ready;
	logic action = 1'b0;
	logic signed [15:0] rect_x = '0;
	logic signed [15:0] rect_y = '0;
	logic [14:0] rect_w = '0;
	logic [14:0] rect_h = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [11:0] out_x;
	logic [11:0] out_y;
	logic [12:0] out_w;
	logic [12:0] out_h;
	logic region_valid;
	logic last;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	rect_t dirty_list[dra_pkg::MaxRegions];
	int dirty_count;
	int scr_w;
	int scr_h;
	region_out_t flush_queue[$];
	int errors;
	int burst_left;
	int stall_mode;

	dirty_rect_accumulator_top u_top (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic bit rects_touch(rect_t a, rect_t b);
		return a.x <= b.x + b.w && b.x <= a.x + a.w && a.y <= b.y + b.h && b.y <= a.y + a.h;
	endfunction

	function automatic rect_t rect_union(rect_t a, rect_t b);
		rect_t r;
		int rt;
		int bt;
		rt = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
		bt = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
		r.x = (a.x < b.x) ? a.x : b.x;
		r.y = (a.y < b.y) ? a.y : b.y;
		r.w = rt - r.x;
		r.h = bt - r.y;
		return r;
	endfunction

	task automatic merge_rect(int x, int y, int w, int h);
		rect_t r;
		rect_t m;
		int sw;
		int sh;
		int l;
		int t;
		int rt;
		int bt;
		int i;
		int best;
		longint unsigned g;
		longint unsigned best_g;
		sw = scr_w > 4096 ? 4096 : scr_w;
		sh = scr_h > 4096 ? 4096 : scr_h;
		l = x > 0 ? x : 0;
		t = y > 0 ? y : 0;
		rt = (x + w < sw) ? x + w : sw;
		bt = (y + h < sh) ? y + h : sh;
		if (l >= rt || t >= bt) return;
		r.x = l;
		r.y = t;
		r.w = rt - l;
		r.h = bt - t;
		i = 0;
		while (i < dirty_count) begin
			if (!rects_touch(dirty_list[i], r)) begin
				i++;
			end else begin
				r = rect_union(dirty_list[i], r);
				dirty_count--;
				dirty_list[i] = dirty_list[dirty_count];
				i = 0;
			end
		end
		if (dirty_count < dra_pkg::MaxRegions) begin
			dirty_list[dirty_count] = r;
			dirty_count++;
			return;
		end
		best = 0;
		best_g = 0;
		for (i = 0; i < dra_pkg::MaxRegions; i++) begin
			m = rect_union(dirty_list[i], r);
			g = 32'(m.w * m.h - dirty_list[i].w * dirty_list[i].h);
			if (i == 0 || g < best_g) begin
				best = i;
				best_g = g;
			end
		end
		dirty_list[best] = rect_union(dirty_list[best], r);
	endtask

	task automatic predict_flush();
		region_out_t e;
		if (dirty_count == 0) begin
			e = '0;
			e.lst = 1'b1;
			flush_queue.push_back(e);
		end
		for (int i = 0; i < dirty_count; i++) begin
			e.x = dirty_list[i].x[11:0];
			e.y = dirty_list[i].y[11:0];
			e.w = dirty_list[i].w[12:0];
			e.h = dirty_list[i].h[12:0];
			e.rv = 1'b1;
			e.lst = (i == dirty_count - 1);
			flush_queue.push_back(e);
		end
		dirty_count = 0;
	endtask

	// Bursty sender: hold valid until accepted, gaps between bursts.
	task automatic send_item(logic act, int x, int y, int w, int h);
		if (burst_left == 0) begin
			valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
		end else begin
			burst_left--;
		end
		valid <= 1'b1;
		action <= act;
		rect_x <= x[15:0];
		rect_y <= y[15:0];
		rect_w <= w[14:0];
		rect_h <= h[14:0];
		@(posedge clk);
		while (!ready) @(posedge clk);
		if (act == dra_pkg::ActAdd) begin
			merge_rect($signed(x[15:0]), $signed(y[15:0]), w[14:0], h[14:0]);
		end else begin
			predict_flush();
		end
		@(negedge clk);
		if (burst_left == 0) valid <= 1'b0;
	endtask

	task automatic drain();
		valid <= 1'b0;
		while (flush_queue.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic cfg_write(logic [2:0] addr, int value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == AddrWidth) scr_w = value & 32'h1FFF;
		else scr_h = value & 32'h1FFF;
	endtask

	task automatic set_screen(int w, int h);
		drain();
		cfg_write(AddrWidth, w);
		cfg_write(AddrHeight, h);
	endtask

	// Receiver ready per mode: always ready in mode 0, random stalls in the other modes.
	always @(negedge clk) begin
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 1) == 0);
		endcase
	end

	always @(posedge clk) begin
		region_out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (flush_queue.size() == 0) begin
				$display("%0t unexpected result x=%0d y=%0d w=%0d h=%0d", $time,
					out_x, out_y, out_w, out_h);
				errors++;
			end else begin
				e = flush_queue.pop_front();
				if ({out_x, out_y, out_w, out_h, region_valid, last} !== e) begin
					$display("%0t mismatch exp x=%0d y=%0d w=%0d h=%0d v=%0d l=%0d",
						$time, e.x, e.y, e.w, e.h, e.rv, e.lst);
					$display("%0t          act x=%0d y=%0d w=%0d h=%0d v=%0d l=%0d",
						$time, out_x, out_y, out_w, out_h, region_valid, last);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_item(dra_pkg::ActFlush, 0, 0, 0, 0);
		send_item(dra_pkg::ActAdd, -32768, -32768, 32767, 32767);
		send_item(dra_pkg::ActFlush, 0, 0, 0, 0);
		send_item(dra_pkg::ActAdd, 10, 10, 0, 5);
		send_item(dra_pkg::ActAdd, 10, 10, 5, 0);
		send_item(dra_pkg::ActAdd, 400, 10, 5, 5);
		send_item(dra_pkg::ActAdd, 32767, 32767, 32767, 32767);
		send_item(dra_pkg::ActAdd, 10, 10, 10, 10);
		send_item(dra_pkg::ActAdd, 20, 10, 10, 10);
		send_item(dra_pkg::ActAdd, 100, 100, 5, 5);
		send_item(dra_pkg::ActAdd, 0, 300, 10, 10);
		send_item(dra_pkg::ActFlush, 0, 0, 0, 0);
		for (int i = 0; i < 9; i++) send_item(dra_pkg::ActAdd, i * 30, i * 25, 10, 10);
		send_item(dra_pkg::ActAdd, 305, 5, 4, 4);
		send_item(dra_pkg::ActFlush, 0, 0, 0, 0);
	endtask

	task automatic test_screen_extremes();
		set_screen(0, 0);
		send_item(dra_pkg::ActAdd, 0, 0, 100, 100);
		send_item(dra_pkg::ActFlush, 0, 0, 0, 0);
		set_screen(8191, 8191);
		send_item(dra_pkg::ActAdd, -5, -5, 32767, 32767);
		send_item(dra_pkg::ActAdd, 4095, 0, 1, 1);
		send_item(dra_pkg::ActFlush, 0, 0, 0, 0);
		set_screen(1, 4096);
		send_item(dra_pkg::ActAdd, 0, 4095, 1, 1);
		send_item(dra_pkg::ActAdd, 0, 0, 1, 1);
		send_item(dra_pkg::ActFlush, 0, 0, 0, 0);
	endtask

	task automatic test_random(int count, int sw, int sh);
		int x;
		int y;
		set_screen(sw, sh);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(dra_pkg::ActFlush, $urandom, $urandom, $urandom, $urandom);
			end else if ($urandom_range(0, 7) == 0) begin
				send_item(dra_pkg::ActAdd, $urandom, $urandom, $urandom, $urandom);
			end else begin
				x = $urandom_range(0, sw + 20) - 10;
				y = $urandom_range(0, sh + 20) - 10;
				send_item(dra_pkg::ActAdd, x, y, $urandom_range(0, sw / 6 + 2),
					$urandom_range(0, sh / 6 + 2));
			end
			if (i == count / 2) drain();
		end
		send_item(dra_pkg::ActFlush, 0, 0, 0, 0);
	endtask

	initial begin
		errors = 0;
		burst_left = 0;
		stall_mode = 0;
		dirty_count = 0;
		scr_w = dra_pkg::ResetWidth;
		scr_h = dra_pkg::ResetHeight;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		stall_mode = 1;
		test_screen_extremes();
		test_random(120, 320, 240);
		stall_mode = 2;
		test_random(120, 64, 48);
		stall_mode = 1;
		test_random(110, 4096, 4096);
		drain();
		if (errors == 0 && flush_queue.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+design
design/dra_pkg.sv
design/dirty_rect_accumulator_top.sv
tb/dirty_rect_accumulator_top_tb.sv
